FILE: src/nsr_pkg.sv
// Shared types, constants and microcode ROM for the square root core.
`default_nettype none

package nsr_pkg;

  localparam int ROOT_WIDTH = 24;
  localparam int STEP_W = 2;

  // Program step addresses
  localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 2'd1;
  localparam logic [STEP_W-1:0] STEP_ITER  = 2'd2;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 2'd3;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_IDLE,
    COND_NEG,
    COND_MORE,
    COND_ALWAYS
  } cond_t;

  typedef struct packed {
    logic              load;
    logic              iter;
    logic              emit;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic last;
    logic neg;
  } status_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{load: 1'b0, iter: 1'b0, emit: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.load   = 1'b1;
        w.cond   = COND_IDLE;
        w.target = STEP_IDLE;
      end
      STEP_CHECK: begin
        w.cond   = COND_NEG;
        w.target = STEP_EMIT;
      end
      STEP_ITER: begin
        w.iter   = 1'b1;
        w.cond   = COND_MORE;
        w.target = STEP_ITER;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: src/newton_square_root_core.sv
// Top level of the fixed-point floor square root core.
//
// Usage: drive radicand (signed, FRACTION_BITS fraction bits) and raise
// start; the word is taken at a clock edge where start is high and busy is
// low. One result word follows per input: done is high for exactly one
// cycle with root (unsigned, same fraction bits, rounded down) and
// negative_error. A negative word gives negative_error = 1 and root = 0.
// The receiver cannot stall; the result is only valid in the done cycle.
//
// Steps: the sequencer runs CHECK, then PAIRS ITER steps of one root bit
// each through the shared compare/subtract unit, then EMIT; done is
// registered from EMIT. PAIRS = ceil((DATA_WIDTH - 1 + FRACTION_BITS) / 2),
// 24 at the defaults. A negative word skips from CHECK straight to EMIT.
// busy drops in the done cycle, so a new word can be taken there, but
// none is taken while a word is still in progress.
// Reset (rst, synchronous) returns the microcode sequencer to its idle
// step and clears done.
`default_nettype none

module newton_square_root_core
  import nsr_pkg::*;
#(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [DATA_WIDTH-1:0] radicand,
  output logic                       done,
  output logic [ROOT_WIDTH-1:0]      root,
  output logic                       negative_error
);

  ctrl_t   ctrl;
  status_t status;
  logic    load_en;

  assign load_en = ctrl.load && start;

  nsr_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  nsr_datapath #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .load_en        (load_en),
    .radicand       (radicand),
    .status         (status),
    .done           (done),
    .root           (root),
    .negative_error (negative_error)
  );

endmodule

`default_nettype wire

FILE: src/nsr_sequencer.sv
// Step counter, microcode fetch and jump logic.
`default_nettype none

module nsr_sequencer
  import nsr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output ctrl_t        ctrl,
  output logic         busy
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  assign ctrl = ucode(step);
  assign busy = (step != STEP_IDLE);

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:   take = 1'b0;
      COND_IDLE:   take = !start;
      COND_NEG:    take = status.neg;
      COND_MORE:   take = !status.last;
      COND_ALWAYS: take = 1'b1;
      default:     take = 1'b1;
    endcase
    step_next = take ? ctrl.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/nsr_datapath.sv
// Digit-by-digit root datapath: radicand shifter, remainder, root and result registers.
`default_nettype none

module nsr_datapath
  import nsr_pkg::*;
#(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctrl_t                 ctrl,
  input  wire logic                  load_en,
  input  wire logic [DATA_WIDTH-1:0] radicand,
  output status_t                    status,
  output logic                       done,
  output logic [ROOT_WIDTH-1:0]      root,
  output logic                       negative_error
);

  localparam int TOTAL = DATA_WIDTH - 1 + FRACTION_BITS;
  localparam int NBITS = TOTAL + (TOTAL % 2);
  localparam int PAIRS = NBITS / 2;
  localparam int RW    = PAIRS + 2;
  localparam int CW    = $clog2(PAIRS + 1);

  logic [NBITS-1:0] nbuf;
  logic [RW-1:0]    rem;
  logic [PAIRS-1:0] rt;
  logic [CW-1:0]    cnt;
  logic             neg;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;

  assign rem_sh = {rem[PAIRS-1:0], nbuf[NBITS-1 -: 2]};
  assign trial  = {rt, 2'b01};
  assign ge     = (rem_sh >= trial);

  assign status.last = (cnt == CW'(1));
  assign status.neg  = neg;

  always_ff @(posedge clk) begin
    if (load_en) begin
      nbuf <= NBITS'(radicand[DATA_WIDTH-2:0]) << FRACTION_BITS;
      rem  <= '0;
      rt   <= '0;
      cnt  <= CW'(PAIRS);
      neg  <= radicand[DATA_WIDTH-1];
    end else if (ctrl.iter) begin
      nbuf <= nbuf << 2;
      rem  <= ge ? rem_sh - trial : rem_sh;
      rt   <= {rt[PAIRS-2:0], ge};
      cnt  <= cnt - CW'(1);
    end
    if (ctrl.emit) begin
      // root stays cleared on a negative word since no iteration step ran
      root           <= ROOT_WIDTH'(rt);
      negative_error <= neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.emit;
    end
  end

endmodule

`default_nettype wire

FILE: src/nsr_checker.sv
// Port-level assertions for the square root core and their bind.
`default_nettype none

module nsr_checker
  import nsr_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done,
  input wire logic [ROOT_WIDTH-1:0] root,
  input wire logic                  negative_error
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_neg_zero: assert property (@(posedge clk) disable iff (rst)
    done && negative_error |-> root == '0)
    else $error("nonzero root on negative word");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without start");

endmodule

bind newton_square_root_core nsr_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .root           (root),
  .negative_error (negative_error)
);

`default_nettype wire

FILE: tb/newton_square_root_core_tb.sv
// Testbench for the square root core: directed table plus random words against a predictor.
`timescale 1ns / 100ps

module newton_square_root_core_tb
  import nsr_pkg::*;
();

  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int RANDOM_WORDS = 1150;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [ROOT_WIDTH-1:0] root;
    logic                  neg;
  } sqrt_result_t;

  typedef struct packed {
    logic [DATA_W-1:0]     value;
    logic                  known;
    logic [ROOT_WIDTH-1:0] root;
    logic                  neg;
  } sqrt_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [DATA_W-1:0]     radicand;
  logic                  done;
  logic [ROOT_WIDTH-1:0] root;
  logic                  negative_error;

  // typed expectation that rides along with the word being offered
  logic                  row_known;
  logic [ROOT_WIDTH-1:0] row_root;
  logic                  row_neg;

  sqrt_result_t pending_roots[$];
  sqrt_row_t    sqrt_rows[$];
  sqrt_result_t got;
  sqrt_result_t want;
  int           mismatches;
  int           words_in;
  int           words_out;
  int           negatives_in;
  int           zeros_in;

  newton_square_root_core #(
    .DATA_WIDTH    (DATA_W),
    .FRACTION_BITS (FRAC_W)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .radicand       (radicand),
    .done           (done),
    .root           (root),
    .negative_error (negative_error)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Build the largest root whose square fits under radicand * 2^FRAC_W, bit by bit.
  function automatic sqrt_result_t predict_root(input logic [DATA_W-1:0] value);
    logic [63:0]           scaled;
    logic [63:0]           trial;
    logic [ROOT_WIDTH-1:0] acc;
    sqrt_result_t          res;
    if (value[DATA_W-1]) begin
      res.root = '0;
      res.neg  = 1'b1;
      return res;
    end
    scaled = {{(64-DATA_W+1){1'b0}}, value[DATA_W-2:0]} << FRAC_W;
    acc    = '0;
    for (int b = ROOT_WIDTH - 1; b >= 0; b--) begin
      trial = {{(64-ROOT_WIDTH){1'b0}}, acc | (ROOT_WIDTH'(1) << b)};
      if (trial * trial <= scaled)
        acc = acc | (ROOT_WIDTH'(1) << b);
    end
    res.root = acc;
    res.neg  = 1'b0;
    return res;
  endfunction

  task automatic add_row(input logic [DATA_W-1:0] value, input bit known,
                         input int unsigned r, input bit n);
    sqrt_rows.push_back(sqrt_row_t'{value: value, known: known,
                                    root: r[ROOT_WIDTH-1:0], neg: n});
  endtask

  // Offer one word after a gap, then hold it until the core takes it.
  task automatic send_word(input sqrt_row_t row, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    radicand  <= row.value;
    row_known <= row.known;
    row_root  <= row.root;
    row_neg   <= row.neg;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [DATA_W-1:0] random_radicand();
    int unsigned t;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return $urandom | 32'h8000_0000;
      4: begin
        t = $urandom_range(0, 46340);
        return t * t;
      end
      5: begin
        t = $urandom_range(1, 46340);
        return ($urandom_range(0, 1) != 0) ? t * t - 1 : t * t + 1;
      end
      6:       return $urandom_range(0, 255);
      7:       return 32'h7FFF_FFFF - $urandom_range(0, 65535);
      8:       return 32'd1 << $urandom_range(0, 30);
      default: return $urandom_range(0, 32767) << FRAC_W;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        words_out++;
        got.root = root;
        got.neg  = negative_error;
        if (pending_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word root=%0d negative_error=%0b",
                     $realtime, got.root, got.neg);
        end else begin
          want = pending_roots.pop_front();
          if (got.root !== want.root || got.neg !== want.neg) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch root exp=%0d got=%0d negative_error exp=%0b got=%0b",
                       $realtime, want.root, got.root, want.neg, got.neg);
          end
        end
      end
      if (start && !busy) begin
        words_in++;
        if (radicand[DATA_W-1])
          negatives_in++;
        if (radicand == '0)
          zeros_in++;
        if (row_known)
          pending_roots.push_back(sqrt_result_t'{root: row_root, neg: row_neg});
        else
          pending_roots.push_back(predict_root(radicand));
      end
    end
  end

  initial begin
    sqrt_row_t row;
    bit        burst;
    int        gap;

    rst          = 1'b1;
    start        = 1'b0;
    radicand     = '0;
    row_known    = 1'b0;
    row_root     = '0;
    row_neg      = 1'b0;
    mismatches   = 0;
    words_in     = 0;
    words_out    = 0;
    negatives_in = 0;
    zeros_in     = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_row(32'h0000_0000, 1, 0, 0);
    add_row(32'h0000_0001, 1, 256, 0);
    add_row(32'h0000_0004, 1, 512, 0);
    add_row(32'h0001_0000, 1, 65536, 0);
    add_row(32'h0004_0000, 1, 131072, 0);
    add_row(32'h4000_0000, 1, 8388608, 0);
    add_row(32'h7FFE_A810, 1, 11863040, 0);
    add_row(32'h7FFF_FFFF, 1, 11863283, 0);
    add_row(32'h8000_0000, 1, 0, 1);
    add_row(32'h8000_0001, 1, 0, 1);
    add_row(32'hFFFF_0000, 1, 0, 1);
    add_row(32'hFFFF_FFFF, 1, 0, 1);
    add_row(32'h0000_0002, 0, 0, 0);
    add_row(32'h0000_0003, 0, 0, 0);
    add_row(32'h0000_0100, 0, 0, 0);
    add_row(32'h0001_0001, 0, 0, 0);
    add_row(32'h3FFF_FFFF, 0, 0, 0);
    add_row(32'h7FFE_A80F, 0, 0, 0);
    add_row(32'h7FFF_0000, 0, 0, 0);
    add_row(32'h5555_5555, 0, 0, 0);
    add_row(32'h2AAA_AAAA, 0, 0, 0);

    foreach (sqrt_rows[i])
      send_word(sqrt_rows[i], $urandom_range(0, 8));

    burst = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // switch between back-to-back stretches and random gaps
      if (n % 50 == 0)
        burst = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 3) begin
        start <= 1'b0;
        while (pending_roots.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      row.value = random_radicand();
      row.known = 1'b0;
      row.root  = '0;
      row.neg   = 1'b0;
      gap = burst ? 0 : $urandom_range(0, 8);
      send_word(row, gap);
    end
    start <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d negative, %0d zero), %0d result words checked.",
             words_in, negatives_in, zeros_in, words_out);
    $display("Covered field extremes, perfect squares and neighbors, and back-to-back bursts.");
    if (mismatches == 0 && pending_roots.size() == 0)
      $display("** newton_square_root_core: PASSED **");
    else
      $display("** newton_square_root_core: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d result words outstanding.", pending_roots.size());
    $display("** newton_square_root_core: FAILED **");
    $finish;
  end

endmodule
